@@ rtl/i2cms_pkg.sv @@
// Shared command codes, queue entry type and helpers for the I2C master sequencer.
package i2cms_pkg;

	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;
	localparam logic [2:0] CMD_SACK  = 3'd5;
	localparam logic [2:0] CMD_RACK  = 3'd6;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int PHASE_W = 5;

	// One classified tick as it sits in the queue.
	typedef struct packed {
		logic       is_cmd;
		logic [2:0] cmd;
		logic [7:0] data;
		logic       sda_in;
	} tick_t;

	// Handshake between queue and its neighbors.
	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

	// Number of pin actions in a command.
	function automatic logic [PHASE_W-1:0] cmd_len(input logic [2:0] cmd);
		logic [PHASE_W-1:0] len;
		case (cmd)
			CMD_START: len = PHASE_W'(4);
			CMD_STOP:  len = PHASE_W'(3);
			CMD_WRITE: len = PHASE_W'(24);
			CMD_READ:  len = PHASE_W'(17);
			default:   len = PHASE_W'(3);
		endcase
		return len;
	endfunction

endpackage

@@ rtl/i2c_master_bit_sequencer_core.sv @@
// Top level of the I2C master bit sequencer: front end, request queue, line sequencer.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------------
//  request | req_valid / req_ready  | mode[2:0], data[7:0], sda_in
//  result  | res_valid / res_ready  | scl, sda, busy_res, done_res, read_data[7:0],
//          |                        | ack_in, rejected
//
//  One request in, one result out; one request per clock while results are taken.
//  Each request passes through the two-entry queue, then the result register.
//  The sequencer pops a queued request whenever its result register is empty or
//  being taken, so a held result does not block intake until the queue fills.
//  arst_n clears queue, result register and line state (SCL and SDA released, idle).
//  Each request is one tick; start 4, stop 3, write 24, read 17, acks 3 ticks.
module i2c_master_bit_sequencer_core import i2cms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [2:0] mode,
	input  logic [7:0] data,
	input  logic       sda_in,
	output logic       res_valid,
	input  logic       res_ready,
	output logic       scl,
	output logic       sda,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_data,
	output logic       ack_in,
	output logic       rejected
);

	hs_t   push_hs;
	logic  push_ready;
	tick_t push_tick;
	logic  pop_valid;
	logic  pop;
	tick_t pop_tick;

	// Decode mode; unused code becomes "no command".
	i2cms_front u_front (
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.mode       (mode),
		.data       (data),
		.sda_in     (sda_in),
		.push_hs    (push_hs),
		.push_ready (push_ready),
		.push_tick  (push_tick)
	);

	// Short queue decouples intake from the sequencer and result stalls.
	i2cms_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_hs    (push_hs),
		.push_tick  (push_tick),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_tick   (pop_tick)
	);

	// One pin action per popped tick; busy commands reject new ones.
	i2cms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_tick  (pop_tick),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.scl       (scl),
		.sda       (sda),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.read_data (read_data),
		.ack_in    (ack_in),
		.rejected  (rejected)
	);

endmodule

@@ rtl/i2cms_front.sv @@
// Request front end: accepts ticks and decodes the mode field into a queue entry.
module i2cms_front import i2cms_pkg::*; (
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [2:0] mode,
	input  logic [7:0] data,
	input  logic       sda_in,
	output hs_t        push_hs,
	input  logic       push_ready,
	output tick_t      push_tick
);

	logic is_cmd;

	// Unused mode code counts as no command.
	always_comb begin
		is_cmd = mode inside {[CMD_START:CMD_RACK]};
	end

	assign push_tick.is_cmd = is_cmd;
	assign push_tick.cmd    = is_cmd ? mode : CMD_NONE;
	assign push_tick.data   = data;
	assign push_tick.sda_in = sda_in;

	assign push_hs.valid = req_valid;
	assign push_hs.ready = push_ready;
	assign req_ready     = push_ready;

endmodule

@@ rtl/i2cms_queue.sv @@
// Two-entry request queue between front end and sequencer.
module i2cms_queue import i2cms_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  hs_t   push_hs,
	input  tick_t push_tick,
	output logic  push_ready,
	output logic  pop_valid,
	input  logic  pop,
	output tick_t pop_tick
);

	tick_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_hs.valid && push_hs.ready;
	assign do_pop     = pop && pop_valid;
	assign pop_tick   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/i2cms_back.sv @@
// Line sequencer: runs one pin action per popped tick and holds the result register.
module i2cms_back import i2cms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	input  tick_t      pop_tick,
	output logic       pop,
	output logic       res_valid,
	input  logic       res_ready,
	output logic       scl,
	output logic       sda,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_data,
	output logic       ack_in,
	output logic       rejected
);

	logic [2:0]         active_q;
	logic [PHASE_W-1:0] phase_q;
	logic [1:0]         tri_q;
	logic [7:0]         shift_q;
	logic               scl_q;
	logic               sda_q;
	logic [7:0]         rx_q;
	logic               ack_q;
	logic               done_q;
	logic               rej_q;
	logic               res_valid_q;

	logic [2:0]         eff_cmd;
	logic [PHASE_W-1:0] eff_ph;
	logic [1:0]         eff_tri;
	logic [7:0]         eff_sb;
	logic [2:0]         active_n;
	logic [PHASE_W-1:0] phase_n;
	logic [1:0]         tri_n;
	logic [7:0]         shift_n;
	logic               scl_n;
	logic               sda_n;
	logic [7:0]         rx_n;
	logic               ack_n;
	logic               done_n;
	logic               rej_n;

	// Result slot is free or draining this cycle.
	assign pop = pop_valid && (!res_valid_q || res_ready);

	always_comb begin
		rej_n = 1'b0;
		if (active_q != CMD_NONE) begin
			rej_n   = pop_tick.is_cmd;
			eff_cmd = active_q;
			eff_ph  = phase_q;
			eff_tri = tri_q;
			eff_sb  = shift_q;
		end else begin
			eff_cmd = pop_tick.cmd;
			eff_ph  = '0;
			eff_tri = '0;
			eff_sb  = pop_tick.is_cmd ? pop_tick.data : shift_q;
		end

		scl_n   = scl_q;
		sda_n   = sda_q;
		shift_n = eff_sb;
		ack_n   = ack_q;
		rx_n    = rx_q;
		case (eff_cmd)
			CMD_START: begin
				case (eff_ph)
					PHASE_W'(0): sda_n = 1'b1;
					PHASE_W'(1): scl_n = 1'b1;
					PHASE_W'(2): sda_n = 1'b0;
					default:     scl_n = 1'b0;
				endcase
			end
			CMD_STOP: begin
				case (eff_ph)
					PHASE_W'(0): sda_n = 1'b0;
					PHASE_W'(1): scl_n = 1'b1;
					default:     sda_n = 1'b1;
				endcase
			end
			CMD_WRITE: begin
				// tri counter tracks phase mod 3: data, clock high, clock low
				case (eff_tri)
					2'd0: sda_n = eff_sb[7];
					2'd1: scl_n = 1'b1;
					default: begin
						scl_n   = 1'b0;
						shift_n = {eff_sb[6:0], 1'b0};
					end
				endcase
			end
			CMD_READ: begin
				if (eff_ph == '0) begin
					sda_n   = 1'b1;
					shift_n = '0;
				end else if (eff_ph[0]) begin
					scl_n   = 1'b1;
					shift_n = {eff_sb[6:0], pop_tick.sda_in};
				end else begin
					scl_n = 1'b0;
				end
			end
			CMD_SACK: begin
				case (eff_ph)
					PHASE_W'(0): sda_n = eff_sb[0];
					PHASE_W'(1): scl_n = 1'b1;
					default:     scl_n = 1'b0;
				endcase
			end
			CMD_RACK: begin
				case (eff_ph)
					PHASE_W'(0): sda_n = 1'b1;
					PHASE_W'(1): begin
						scl_n = 1'b1;
						ack_n = pop_tick.sda_in;
					end
					default: scl_n = 1'b0;
				endcase
			end
			default: begin
			end
		endcase

		phase_n  = eff_ph + 1'b1;
		tri_n    = (eff_tri == 2'd2) ? 2'd0 : eff_tri + 1'b1;
		active_n = eff_cmd;
		done_n   = 1'b0;
		if (eff_cmd == CMD_NONE) begin
			phase_n = phase_q;
			tri_n   = tri_q;
		end else if (phase_n >= cmd_len(eff_cmd)) begin
			if (eff_cmd == CMD_READ) begin
				rx_n = shift_n;
			end
			active_n = CMD_NONE;
			phase_n  = '0;
			tri_n    = '0;
			done_n   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= CMD_NONE;
			phase_q     <= '0;
			tri_q       <= '0;
			shift_q     <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			rx_q        <= '0;
			ack_q       <= 1'b1;
			done_q      <= 1'b0;
			rej_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= active_n;
				phase_q  <= phase_n;
				tri_q    <= tri_n;
				shift_q  <= shift_n;
				scl_q    <= scl_n;
				sda_q    <= sda_n;
				rx_q     <= rx_n;
				ack_q    <= ack_n;
				done_q   <= done_n;
				rej_q    <= rej_n;
			end
			if (pop) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Line state doubles as the result payload; it moves only on a pop.
	assign res_valid = res_valid_q;
	assign scl       = scl_q;
	assign sda       = sda_q;
	assign busy_res  = (active_q != CMD_NONE);
	assign done_res  = done_q;
	assign read_data = rx_q;
	assign ack_in    = ack_q;
	assign rejected  = rej_q;

endmodule

@@ bench/i2c_master_bit_sequencer_core_tb.sv @@
// Self-checking testbench for the I2C master bit sequencer core.
module i2c_master_bit_sequencer_core_tb;
	import i2cms_pkg::*;

	// Mode 7 has no meaning: no command, never rejected.
	localparam logic [2:0] MODE_UNUSED = 3'd7;
	// Share of cycles in which each side idles, in percent.
	localparam int IDLE_PCT    = 26;
	localparam int REQ_TARGET  = 750;
	// Cycles with no handshake on either channel before the run is given up.
	localparam int STALL_LIMIT = 1000;
	// Extra wait after the run drains, as margin.
	localparam int TAIL_CYCLES = 8;

	// One tick request as the driver will present it.
	typedef struct {
		logic [2:0] mode;
		logic [7:0] data;
		logic       sda_in;
		bit         drain_first;	// wait for all results before presenting it
	} tick_req_t;

	// Pin levels and status that one tick produces.
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] read_data;
		logic       ack;
		logic       rejected;
	} line_result_t;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	logic [2:0] mode;
	logic [7:0] data;
	logic       sda_in;
	logic       res_valid;
	logic       res_ready;
	logic       scl;
	logic       sda;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       ack_in;
	logic       rejected;

	i2c_master_bit_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.mode      (mode),
		.data      (data),
		.sda_in    (sda_in),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.scl       (scl),
		.sda       (sda),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.read_data (read_data),
		.ack_in    (ack_in),
		.rejected  (rejected)
	);

	tick_req_t    pending_ticks[$];	// requests still to be presented
	line_result_t expected_lines[$];	// predicted results, oldest first

	int  accepted_reqs;
	int  stall_cycles;
	int  failures;
	bit  timed_out;

	// Shadow of the sequencer state.
	logic [2:0] seq_cmd;
	logic [4:0] seq_phase;
	logic [7:0] seq_shift;
	logic       seq_scl;
	logic       seq_sda;
	logic [7:0] seq_rx_byte;
	logic       seq_ack;

	// No-idle stretch in the middle of the run, on both sides.
	wire calm = (accepted_reqs >= 300) && (accepted_reqs < 450);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Ticks a command occupies.
	function automatic int ticks_of(input logic [2:0] cmd);
		case (cmd)
			CMD_START: return 4;
			CMD_STOP:  return 3;
			CMD_WRITE: return 24;
			CMD_READ:  return 17;
			default:   return 3;
		endcase
	endfunction

	// Advance the shadow sequencer by one tick and return what the pins show.
	task automatic predict_tick(input logic [2:0] m, input logic [7:0] d, input logic si,
			output line_result_t r);
		logic is_cmd;
		logic rej;
		logic fin;
		is_cmd = (m >= CMD_START) && (m <= CMD_RACK);
		rej = 1'b0;
		fin = 1'b0;
		// A command is taken only when idle; while busy it is flagged and dropped.
		if (seq_cmd != CMD_NONE) begin
			rej = is_cmd;
		end else if (is_cmd) begin
			seq_cmd = m;
			seq_phase = 5'd0;
			seq_shift = d;
		end
		if (seq_cmd != CMD_NONE) begin
			case (seq_cmd)
				CMD_START: begin
					case (seq_phase)
						5'd0:    seq_sda = 1'b1;
						5'd1:    seq_scl = 1'b1;
						5'd2:    seq_sda = 1'b0;
						default: seq_scl = 1'b0;
					endcase
				end
				CMD_STOP: begin
					case (seq_phase)
						5'd0:    seq_sda = 1'b0;
						5'd1:    seq_scl = 1'b1;
						default: seq_sda = 1'b1;
					endcase
				end
				CMD_WRITE: begin
					// Per bit: drive SDA from MSB, raise SCL, drop SCL and shift.
					case (seq_phase % 5'd3)
						5'd0: seq_sda = seq_shift[7];
						5'd1: seq_scl = 1'b1;
						default: begin
							seq_scl = 1'b0;
							seq_shift = {seq_shift[6:0], 1'b0};
						end
					endcase
				end
				CMD_READ: begin
					// Release SDA first, then sample on every SCL rise.
					if (seq_phase == 5'd0) begin
						seq_sda = 1'b1;
						seq_shift = 8'd0;
					end else if (seq_phase[0]) begin
						seq_scl = 1'b1;
						seq_shift = {seq_shift[6:0], si};
					end else begin
						seq_scl = 1'b0;
					end
				end
				CMD_SACK: begin
					case (seq_phase)
						5'd0:    seq_sda = seq_shift[0];
						5'd1:    seq_scl = 1'b1;
						default: seq_scl = 1'b0;
					endcase
				end
				default: begin
					case (seq_phase)
						5'd0: seq_sda = 1'b1;
						5'd1: begin
							seq_scl = 1'b1;
							seq_ack = si;
						end
						default: seq_scl = 1'b0;
					endcase
				end
			endcase
			seq_phase = seq_phase + 5'd1;
			if (int'(seq_phase) >= ticks_of(seq_cmd)) begin
				if (seq_cmd == CMD_READ)
					seq_rx_byte = seq_shift;
				seq_cmd = CMD_NONE;
				seq_phase = 5'd0;
				fin = 1'b1;
			end
		end
		r.scl       = seq_scl;
		r.sda       = seq_sda;
		r.busy      = (seq_cmd != CMD_NONE);
		r.done      = fin;
		r.read_data = seq_rx_byte;
		r.ack       = seq_ack;
		r.rejected  = rej;
	endtask

	task automatic push_tick(input logic [2:0] m, input logic [7:0] d, input logic si,
			input bit drain);
		tick_req_t t;
		t.mode = m;
		t.data = d;
		t.sda_in = si;
		t.drain_first = drain;
		pending_ticks.push_back(t);
	endtask

	// A command followed by enough ticks to finish it; noise_pct of the filler
	// ticks carry a random mode, which hits the busy rejection path.
	task automatic push_command(input logic [2:0] cmd, input logic [7:0] d,
			input int noise_pct, input bit drain);
		logic [2:0] m;
		push_tick(cmd, d, 1'($urandom_range(1)), drain);
		for (int i = 1; i < ticks_of(cmd); i++) begin
			m = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(7)) : CMD_NONE;
			push_tick(m, 8'($urandom), 1'($urandom_range(1)), 1'b0);
		end
	endtask

	// Driver: present queued ticks, predict each one as it is accepted.
	always @(posedge clk) begin
		line_result_t r;
		tick_req_t    t;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				predict_tick(mode, data, sda_in, r);
				expected_lines.push_back(r);
				accepted_reqs <= accepted_reqs + 1;
			end
			if (!req_valid || req_ready) begin
				if (pending_ticks.size() > 0 &&
						(!pending_ticks[0].drain_first || expected_lines.size() == 0) &&
						(calm || $urandom_range(99) >= IDLE_PCT)) begin
					t = pending_ticks.pop_front();
					req_valid <= 1'b1;
					mode      <= t.mode;
					data      <= t.data;
					sda_in    <= t.sda_in;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure, compare every taken result with the oldest prediction.
	always @(posedge clk) begin
		line_result_t e;
		if (arst_n) begin
			res_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			if (res_valid && res_ready) begin
				if (expected_lines.size() == 0) begin
					$error("result with no request outstanding");
					failures = failures + 1;
				end else begin
					e = expected_lines.pop_front();
					if (scl !== e.scl) begin
						$error("scl: expected %0d, got %0d", e.scl, scl);
						failures = failures + 1;
					end
					if (sda !== e.sda) begin
						$error("sda: expected %0d, got %0d", e.sda, sda);
						failures = failures + 1;
					end
					if (busy_res !== e.busy) begin
						$error("busy_res: expected %0d, got %0d", e.busy, busy_res);
						failures = failures + 1;
					end
					if (done_res !== e.done) begin
						$error("done_res: expected %0d, got %0d", e.done, done_res);
						failures = failures + 1;
					end
					if (read_data !== e.read_data) begin
						$error("read_data: expected %02h, got %02h", e.read_data, read_data);
						failures = failures + 1;
					end
					if (ack_in !== e.ack) begin
						$error("ack_in: expected %0d, got %0d", e.ack, ack_in);
						failures = failures + 1;
					end
					if (rejected !== e.rejected) begin
						$error("rejected: expected %0d, got %0d", e.rejected, rejected);
						failures = failures + 1;
					end
				end
			end
		end
	end

	// Watchdog: cycles since the last handshake on either channel.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (res_valid && res_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		int next_drain;
		logic [2:0] m;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		mode      = CMD_NONE;
		data      = 8'd0;
		sda_in    = 1'b0;
		res_ready = 1'b0;
		accepted_reqs = 0;
		stall_cycles  = 0;
		failures      = 0;
		timed_out     = 1'b0;

		seq_cmd     = CMD_NONE;
		seq_phase   = 5'd0;
		seq_shift   = 8'd0;
		seq_scl     = 1'b1;
		seq_sda     = 1'b1;
		seq_rx_byte = 8'd0;
		seq_ack     = 1'b1;

		// Directed: idle line, unused mode, each command, extremes of data.
		push_tick(CMD_NONE, 8'h00, 1'b0, 1'b0);
		push_tick(MODE_UNUSED, 8'hFF, 1'b1, 1'b0);
		push_command(CMD_START, 8'h00, 0, 1'b0);
		push_command(CMD_RACK, 8'h00, 0, 1'b0);
		push_command(CMD_SACK, 8'h01, 0, 1'b0);
		push_command(CMD_SACK, 8'hFE, 0, 1'b0);
		push_command(CMD_STOP, 8'h00, 0, 1'b0);
		// Write of all ones, half its filler ticks with random modes; commands must be rejected.
		push_command(CMD_WRITE, 8'hFF, 50, 1'b0);
		push_command(CMD_WRITE, 8'h00, 0, 1'b0);
		push_command(CMD_READ, 8'h00, 0, 1'b0);
		push_command(CMD_RACK, 8'hFF, 0, 1'b0);

		// Random: mostly complete commands with random content, some noise ticks.
		next_drain = pending_ticks.size() + 10;
		while (pending_ticks.size() < REQ_TARGET) begin
			bit drain;
			drain = (pending_ticks.size() >= next_drain);
			if (drain)
				next_drain = next_drain + 200;
			if ($urandom_range(99) < 80) begin
				m = 3'($urandom_range(int'(CMD_RACK), int'(CMD_START)));
				push_command(m, 8'($urandom), 15, drain);
			end else begin
				push_tick(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)), drain);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (!(pending_ticks.size() == 0 && !req_valid && expected_lines.size() == 0) &&
				stall_cycles < STALL_LIMIT)
			@(negedge clk);
		if (stall_cycles >= STALL_LIMIT)
			timed_out = 1'b1;
		else
			repeat (TAIL_CYCLES) @(negedge clk);

		if (!timed_out && failures == 0 && expected_lines.size() == 0)
			$display("i2c_master_bit_sequencer_core: match");
		else
			$display("i2c_master_bit_sequencer_core: mismatch");
		$finish;
	end

endmodule
